FILE: hw/rtl/msst_pkg.sv
`default_nettype none

package msst_pkg;

    // Table geometry and timing
    localparam int SLOTS       = 16;
    localparam int TICK_LEN_MS = 10;

    // Field widths
    localparam int CMD_W   = 2;
    localparam int MS_W    = 20;
    localparam int ID_W    = 16;
    localparam int TICKS_W = 16;

    // Millisecond to tick conversion by reciprocal multiply, one-step correction
    localparam int DIV_SHIFT = MS_W;
    localparam int RECIP_W   = DIV_SHIFT + 1;
    localparam int PROD_W    = MS_W + RECIP_W;
    localparam logic [RECIP_W-1:0] DIV_RECIP = RECIP_W'((64'd1 << DIV_SHIFT) / TICK_LEN_MS);

    // Command codes
    localparam logic [CMD_W-1:0] CMD_START  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CANCEL = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TICK   = 2'd2;

    // Result kinds
    localparam logic [1:0] KIND_START  = 2'd0;
    localparam logic [1:0] KIND_CANCEL = 2'd1;
    localparam logic [1:0] KIND_EXPIRY = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [MS_W-1:0]  duration_ms;
        logic             is_periodic;
        logic [ID_W-1:0]  target_id;
    } req_t;

    typedef struct packed {
        logic [1:0]      result_kind;
        logic            ok;
        logic [ID_W-1:0] timer_id;
        logic            last;
    } rsp_t;

    // Command packet that walks the row of slot cells
    typedef struct packed {
        logic               valid;
        logic [CMD_W-1:0]   cmd;
        logic               periodic;
        logic [TICKS_W-1:0] ticks;
        logic [ID_W-1:0]    target;
        logic [ID_W-1:0]    id;
        logic               found;
        logic               pend_valid;
        logic [ID_W-1:0]    pend_id;
    } pkt_t;

    // Expiry handed from a cell to the output register
    typedef struct packed {
        logic            req;
        logic [ID_W-1:0] id;
    } emit_t;

endpackage

`default_nettype wire

FILE: hw/rtl/msst_cell.sv
`default_nettype none

module msst_cell (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          advance,
    input  wire msst_pkg::pkt_t pkt_in,
    output msst_pkg::pkt_t     pkt_out,
    output msst_pkg::emit_t    emit
);
    import msst_pkg::*;

    logic               active_reg,    active_next;
    logic               periodic_reg,  periodic_next;
    logic [TICKS_W-1:0] reload_reg,    reload_next;
    logic [TICKS_W-1:0] remaining_reg, remaining_next;
    logic [ID_W-1:0]    ident_reg,     ident_next;
    pkt_t               pkt_reg,       pkt_next;

    // Apply the passing command to this slot
    always_comb
    begin
        active_next    = active_reg;
        periodic_next  = periodic_reg;
        reload_next    = reload_reg;
        remaining_next = remaining_reg;
        ident_next     = ident_reg;
        pkt_next       = pkt_in;
        emit           = '0;
        if (pkt_in.valid)
        begin
            case (pkt_in.cmd)
                CMD_START:
                begin
                    // first free slot takes the new timer
                    if (!pkt_in.found && !active_reg)
                    begin
                        active_next    = 1'b1;
                        periodic_next  = pkt_in.periodic;
                        reload_next    = pkt_in.ticks;
                        remaining_next = pkt_in.ticks;
                        ident_next     = pkt_in.id;
                        pkt_next.found = 1'b1;
                    end
                end
                CMD_CANCEL:
                begin
                    // first active slot with a matching id is freed
                    if (!pkt_in.found && active_reg && (ident_reg == pkt_in.target))
                    begin
                        active_next    = 1'b0;
                        pkt_next.found = 1'b1;
                    end
                end
                CMD_TICK:
                begin
                    if (active_reg)
                    begin
                        remaining_next = remaining_reg - TICKS_W'(1);
                        if (remaining_reg == TICKS_W'(1))
                        begin
                            // older pending expiry goes out, this one is held
                            emit.req            = pkt_in.pend_valid;
                            emit.id             = pkt_in.pend_valid ? pkt_in.pend_id : '0;
                            pkt_next.pend_valid = 1'b1;
                            pkt_next.pend_id    = ident_reg;
                            if (periodic_reg)
                            begin
                                remaining_next = reload_reg;
                            end
                            else
                            begin
                                active_next = 1'b0;
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            pkt_reg    <= '0;
        end
        else if (advance)
        begin
            active_reg <= active_next;
            pkt_reg    <= pkt_next;
        end
    end

    // Slot payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            periodic_reg  <= periodic_next;
            reload_reg    <= reload_next;
            remaining_reg <= remaining_next;
            ident_reg     <= ident_next;
        end
    end

    assign pkt_out = pkt_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/multi_slot_soft_timer_table.sv
`default_nettype none

// Soft timer table with SLOTS countdown slots held in a row of cells. Each
// start, cancel or tick item becomes a packet that moves one cell per cycle
// from slot 0 upward while the row is not held by a stalled result; every
// cell acts on the packet as it passes. An item is accepted, its duration is
// converted from milliseconds to ticks (reciprocal multiply, then correction
// and saturation), the packet travels through the row and then retires,
// after which the block is ready again. Stalls on the result side hold the
// row. Expiry results leave in ascending slot order while the packet travels;
// a start or cancel reply, and the final expiry of a tick, leave when the
// packet retires. Command code 3 is accepted and does nothing. One finished
// result waits in the output register while the next item is accepted.
module multi_slot_soft_timer_table (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       req_valid,
    output logic            req_ready,
    input  wire msst_pkg::req_t req,
    output logic            rsp_valid,
    input  wire logic       rsp_ready,
    output msst_pkg::rsp_t  rsp
);
    import msst_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_RUN  = 4'b1000
    } state_t;

    state_t              state_reg, state_next;
    req_t                req_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [ID_W-1:0]     id_counter_reg, id_counter_next;
    pkt_t                launch_reg;
    logic                rsp_valid_reg;
    rsp_t                rsp_reg, rsp_next;

    pkt_t                chain [SLOTS+1];
    emit_t               cell_emit [SLOTS];
    pkt_t                tail;
    logic                tail_req;
    logic                cell_any;
    logic [ID_W-1:0]     cell_id;
    logic                emit_req;
    logic                out_free;
    logic                advance;
    logic                accept;

    logic [RECIP_W-1:0]  quot_est;
    logic [MS_W-1:0]     rem_est;
    logic [RECIP_W-1:0]  quot;
    logic [TICKS_W-1:0]  ticks;

    assign req_ready = (state_reg == ST_IDLE);
    assign accept    = req_valid && req_ready;

    // Row of slot cells
    assign chain[0] = launch_reg;
    for (genvar i = 0; i < SLOTS; i++)
    begin : g_cell
        msst_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .advance (advance),
            .pkt_in  (chain[i]),
            .pkt_out (chain[i+1]),
            .emit    (cell_emit[i])
        );
    end

    // Collect an expiry from whichever cell holds the packet
    always_comb
    begin
        cell_any = 1'b0;
        cell_id  = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            cell_any = cell_any | cell_emit[i].req;
            cell_id  = cell_id | (cell_emit[i].req ? cell_emit[i].id : '0);
        end
    end

    // Retiring packet and its final result
    always_comb
    begin
        tail     = chain[SLOTS];
        tail_req = tail.valid && ((tail.cmd != CMD_TICK) || tail.pend_valid);
        rsp_next = '0;
        if (tail_req)
        begin
            rsp_next.last = 1'b1;
            case (tail.cmd)
                CMD_START:
                begin
                    rsp_next.result_kind = KIND_START;
                    rsp_next.ok          = tail.found;
                    rsp_next.timer_id    = tail.found ? tail.id : '0;
                end
                CMD_CANCEL:
                begin
                    rsp_next.result_kind = KIND_CANCEL;
                    rsp_next.ok          = tail.found;
                    rsp_next.timer_id    = tail.found ? tail.target : '0;
                end
                default:
                begin
                    rsp_next.result_kind = KIND_EXPIRY;
                    rsp_next.ok          = 1'b1;
                    rsp_next.timer_id    = tail.pend_id;
                end
            endcase
        end
        else
        begin
            rsp_next.result_kind = KIND_EXPIRY;
            rsp_next.ok          = 1'b1;
            rsp_next.timer_id    = cell_id;
            rsp_next.last        = 1'b0;
        end
    end

    // The row moves unless a result is due and the output is occupied
    assign emit_req = tail_req || cell_any;
    assign out_free = !rsp_valid_reg || rsp_ready;
    assign advance  = out_free || !emit_req;

    // Tick count: estimate is at most one low, then clamp to at least one tick and saturate to the field
    always_comb
    begin
        quot_est = prod_reg[PROD_W-1:DIV_SHIFT];
        rem_est  = req_reg.duration_ms
                   - MS_W'(quot_est * RECIP_W'(TICK_LEN_MS));
        quot     = quot_est + RECIP_W'(rem_est >= MS_W'(TICK_LEN_MS));
        if (quot == '0)
        begin
            ticks = TICKS_W'(1);
        end
        else if (quot > RECIP_W'({TICKS_W{1'b1}}))
        begin
            ticks = {TICKS_W{1'b1}};
        end
        else
        begin
            ticks = quot[TICKS_W-1:0];
        end
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && ((req.cmd == CMD_START) || (req.cmd == CMD_CANCEL)
                               || (req.cmd == CMD_TICK)))
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                state_next = ST_RUN;
            end
            ST_RUN:
            begin
                if (tail.valid && advance)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Next id, wrapping past the top back to one
    assign id_counter_next = (id_counter_reg == {ID_W{1'b1}}) ? ID_W'(1)
                                                               : id_counter_reg + ID_W'(1);

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            id_counter_reg <= ID_W'(1);
            launch_reg     <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (state_reg == ST_DIV)
            begin
                launch_reg.valid      <= 1'b1;
                launch_reg.cmd        <= req_reg.cmd;
                launch_reg.periodic   <= req_reg.is_periodic;
                launch_reg.ticks      <= ticks;
                launch_reg.target     <= req_reg.target_id;
                launch_reg.id         <= id_counter_reg;
                launch_reg.found      <= 1'b0;
                launch_reg.pend_valid <= 1'b0;
                launch_reg.pend_id    <= '0;
            end
            else if (advance)
            begin
                launch_reg.valid <= 1'b0;
            end

            if (tail.valid && advance && (tail.cmd == CMD_START) && tail.found)
            begin
                id_counter_reg <= id_counter_next;
            end

            if (emit_req && advance)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req;
        end
        if (state_reg == ST_MUL)
        begin
            prod_reg <= PROD_W'(req_reg.duration_ms) * PROD_W'(DIV_RECIP);
        end
        if (emit_req && advance)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/msst_checker.sv
`default_nettype none

module msst_checker (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       req_valid,
    input  wire logic       req_ready,
    input  wire msst_pkg::req_t req,
    input  wire logic       rsp_valid,
    input  wire logic       rsp_ready,
    input  wire msst_pkg::rsp_t rsp
);
    import msst_pkg::*;

    // A stalled result holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("result changed while stalled");

    // A working command keeps the input closed the next cycle
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready
        && ((req.cmd == CMD_START) || (req.cmd == CMD_CANCEL) || (req.cmd == CMD_TICK))
        |=> !req_ready)
        else $error("input reopened during a walk");

    // Start and cancel replies are single results
    a_reply_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && ((rsp.result_kind == KIND_START) || (rsp.result_kind == KIND_CANCEL))
        |-> rsp.last)
        else $error("reply not marked last");

    // Expiries always succeed and carry a real id
    a_expiry: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.result_kind == KIND_EXPIRY) |-> rsp.ok && (rsp.timer_id != '0))
        else $error("bad expiry result");

    // Failures carry id zero
    a_fail_id: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.ok |-> (rsp.timer_id == '0))
        else $error("failure with nonzero id");

endmodule

bind multi_slot_soft_timer_table msst_checker u_checker (.*);

`default_nettype wire

FILE: tb/multi_slot_soft_timer_table_tb.sv
`timescale 1ns / 1ps

module multi_slot_soft_timer_table_tb;
    import msst_pkg::*;

    localparam int RANDOM_ITEMS = 470;
    localparam int SHOWN_ERRORS = 10;
    localparam int DRAIN_LIMIT  = 20000;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct {
        req_t stim;
        bit   typed;
        rsp_t want;
    } plan_row_t;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    req_t req;
    logic rsp_valid;
    logic rsp_ready;
    rsp_t rsp;

    // Shadow copy of the slot table
    logic               shadow_active   [SLOTS];
    logic               shadow_periodic [SLOTS];
    logic [TICKS_W-1:0] shadow_reload   [SLOTS];
    logic [TICKS_W-1:0] shadow_left     [SLOTS];
    logic [ID_W-1:0]    shadow_id       [SLOTS];
    logic [ID_W-1:0]    shadow_next_id;

    rsp_t            pending_results[$];
    rsp_t            head;
    plan_row_t       plan[$];
    logic [ID_W-1:0] live_ids[$];

    bit calm;
    int mismatches;
    int missing;
    int items_in;
    int ignored_cmds;
    int starts_placed;
    int starts_refused;
    int cancels_hit;
    int cancels_missed;
    int expiries;
    int quiet_ticks;

    multi_slot_soft_timer_table dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic req_t mk_req(input logic [CMD_W-1:0] c, input logic [MS_W-1:0] ms,
                                    input logic per, input logic [ID_W-1:0] tid);
        req_t r;
        r.cmd         = c;
        r.duration_ms = ms;
        r.is_periodic = per;
        r.target_id   = tid;
        return r;
    endfunction

    function automatic rsp_t mk_rsp(input logic [1:0] kind, input logic ok,
                                    input logic [ID_W-1:0] id, input logic fin);
        rsp_t r;
        r.result_kind = kind;
        r.ok          = ok;
        r.timer_id    = id;
        r.last        = fin;
        return r;
    endfunction

    // Mostly back to back, sometimes a short gap, rarely a long pause
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        else if (roll < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(4, 30);
    endfunction

    // Mostly a few ticks so slots turn over; sometimes long or saturating
    function automatic logic [MS_W-1:0] pick_ms();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return MS_W'($urandom_range(0, 59));
        else if (roll < 90)
            return MS_W'($urandom_range(60, 2000));
        else
            return MS_W'($urandom_range(0, 20'hFFFFF));
    endfunction

    function automatic int count_active();
        int n;
        n = 0;
        for (int s = 0; s < SLOTS; s++)
            if (shadow_active[s])
                n++;
        return n;
    endfunction

    // Work out the results of one accepted item and advance the shadow table
    task automatic predict_timer_results(input req_t r);
        rsp_t             batch[$];
        logic [MS_W-1:0]  whole;
        logic [TICKS_W-1:0] ticks;
        int               hit;
        hit = -1;
        case (r.cmd)
            CMD_START:
            begin
                whole = MS_W'(r.duration_ms / TICK_LEN_MS);
                if (whole == '0)
                    whole = MS_W'(1);
                ticks = (whole > 20'hFFFF) ? 16'hFFFF : whole[TICKS_W-1:0];
                for (int s = 0; s < SLOTS; s++)
                    if (hit < 0 && !shadow_active[s])
                        hit = s;
                if (hit >= 0)
                begin
                    shadow_active[hit]   = 1'b1;
                    shadow_periodic[hit] = r.is_periodic;
                    shadow_reload[hit]   = ticks;
                    shadow_left[hit]     = ticks;
                    shadow_id[hit]       = shadow_next_id;
                    batch.push_back(mk_rsp(KIND_START, 1'b1, shadow_next_id, 1'b0));
                    shadow_next_id = (shadow_next_id == 16'hFFFF) ? 16'd1 : shadow_next_id + 1'b1;
                    starts_placed++;
                end
                else
                begin
                    batch.push_back(mk_rsp(KIND_START, 1'b0, '0, 1'b0));
                    starts_refused++;
                end
            end
            CMD_CANCEL:
            begin
                for (int s = 0; s < SLOTS; s++)
                    if (hit < 0 && shadow_active[s] && shadow_id[s] == r.target_id)
                        hit = s;
                if (hit >= 0)
                begin
                    shadow_active[hit] = 1'b0;
                    batch.push_back(mk_rsp(KIND_CANCEL, 1'b1, r.target_id, 1'b0));
                    cancels_hit++;
                end
                else
                begin
                    batch.push_back(mk_rsp(KIND_CANCEL, 1'b0, '0, 1'b0));
                    cancels_missed++;
                end
            end
            CMD_TICK:
            begin
                for (int s = 0; s < SLOTS; s++)
                begin
                    if (shadow_active[s])
                    begin
                        shadow_left[s] = shadow_left[s] - 1'b1;
                        if (shadow_left[s] == '0)
                        begin
                            batch.push_back(mk_rsp(KIND_EXPIRY, 1'b1, shadow_id[s], 1'b0));
                            if (shadow_periodic[s])
                                shadow_left[s] = shadow_reload[s];
                            else
                                shadow_active[s] = 1'b0;
                        end
                    end
                end
                expiries += batch.size();
                if (batch.size() == 0)
                    quiet_ticks++;
            end
            default:
                ignored_cmds++;
        endcase
        if (batch.size() > 0)
            batch[batch.size() - 1].last = 1'b1;
        foreach (batch[k])
            pending_results.push_back(batch[k]);
    endtask

    // Hold the item until it is taken, then predict it
    task automatic put_item(input req_t r);
        req       <= r;
        req_valid <= 1'b1;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        predict_timer_results(r);
        if (r.cmd != CMD_UNUSED)
            items_in++;
        @(negedge clk);
    endtask

    task automatic send(input req_t r);
        int gap;
        gap = calm ? 0 : pick_gap();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        put_item(r);
    endtask

    // Sender holds off until every outstanding result has been seen
    task automatic drain_results();
        req_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic gather_live_ids();
        live_ids.delete();
        for (int s = 0; s < SLOTS; s++)
            if (shadow_active[s])
                live_ids.push_back(shadow_id[s]);
    endtask

    task automatic cancel_all_live();
        gather_live_ids();
        foreach (live_ids[k])
            send(mk_req(CMD_CANCEL, pick_ms(), 1'($urandom_range(0, 1)), live_ids[k]));
    endtask

    task automatic add_row(input req_t stim, input bit typed, input rsp_t want);
        plan_row_t row;
        row.stim  = stim;
        row.typed = typed;
        row.want  = want;
        plan.push_back(row);
    endtask

    // Result side: random stalls, none while calm
    initial
    begin
        int stall_left;
        stall_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall_left > 0 && !calm)
            begin
                rsp_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                rsp_ready <= 1'b1;
                stall_left = 0;
                if (!calm && $urandom_range(0, 3) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    // Compare each result with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= SHOWN_ERRORS)
                    $display("%0t: unexpected result kind %0d ok %0d id %0d last %0d",
                             $time, rsp.result_kind, rsp.ok, rsp.timer_id, rsp.last);
            end
            else
            begin
                head = pending_results.pop_front();
                if (rsp.result_kind !== head.result_kind || rsp.ok !== head.ok ||
                    rsp.timer_id !== head.timer_id || rsp.last !== head.last)
                begin
                    mismatches++;
                    if (mismatches <= SHOWN_ERRORS)
                        $display("%0t: want kind/ok/id/last %0d %0d %0d %0d, got %0d %0d %0d %0d",
                                 $time, head.result_kind, head.ok, head.timer_id, head.last,
                                 rsp.result_kind, rsp.ok, rsp.timer_id, rsp.last);
                end
            end
        end
    end

    // Hard stop in case the block hangs
    initial
    begin
        #100_000_000;
        $display("multi_slot_soft_timer_table test failed");
        $finish;
    end

    initial
    begin
        int              roll;
        int              n;
        int              base;
        int              waited;

        rst_n     = 1'b0;
        req_valid = 1'b0;
        req       = '0;
        rsp_ready = 1'b0;
        calm      = 1'b0;
        for (int s = 0; s < SLOTS; s++)
        begin
            shadow_active[s]   = 1'b0;
            shadow_periodic[s] = 1'b0;
            shadow_reload[s]   = '0;
            shadow_left[s]     = '0;
            shadow_id[s]       = '0;
        end
        shadow_next_id = 16'd1;

        // Directed rows: short timeout, quiet tick, unused command, saturation,
        // misses on both id extremes, double cancel, slot reuse
        add_row(mk_req(CMD_START, 20'd0, 1'b0, 16'd0), 1'b1,
                mk_rsp(KIND_START, 1'b1, 16'd1, 1'b1));
        add_row(mk_req(CMD_TICK, 20'd0, 1'b0, 16'd0), 1'b1,
                mk_rsp(KIND_EXPIRY, 1'b1, 16'd1, 1'b1));
        add_row(mk_req(CMD_TICK, 20'd0, 1'b0, 16'd0), 1'b0, '0);
        add_row(mk_req(CMD_UNUSED, 20'hFFFFF, 1'b1, 16'hFFFF), 1'b0, '0);
        add_row(mk_req(CMD_START, 20'hFFFFF, 1'b1, 16'd0), 1'b1,
                mk_rsp(KIND_START, 1'b1, 16'd2, 1'b1));
        add_row(mk_req(CMD_START, 20'd9, 1'b1, 16'd0), 1'b1,
                mk_rsp(KIND_START, 1'b1, 16'd3, 1'b1));
        add_row(mk_req(CMD_START, 20'd20, 1'b0, 16'd0), 1'b1,
                mk_rsp(KIND_START, 1'b1, 16'd4, 1'b1));
        add_row(mk_req(CMD_START, 20'd655359, 1'b0, 16'd0), 1'b1,
                mk_rsp(KIND_START, 1'b1, 16'd5, 1'b1));
        add_row(mk_req(CMD_TICK, 20'd0, 1'b0, 16'd0), 1'b0, '0);
        add_row(mk_req(CMD_TICK, 20'd0, 1'b0, 16'd0), 1'b0, '0);
        add_row(mk_req(CMD_CANCEL, 20'd0, 1'b0, 16'd0), 1'b1,
                mk_rsp(KIND_CANCEL, 1'b0, 16'd0, 1'b1));
        add_row(mk_req(CMD_CANCEL, 20'd0, 1'b0, 16'hFFFF), 1'b1,
                mk_rsp(KIND_CANCEL, 1'b0, 16'd0, 1'b1));
        add_row(mk_req(CMD_CANCEL, 20'd0, 1'b0, 16'd2), 1'b1,
                mk_rsp(KIND_CANCEL, 1'b1, 16'd2, 1'b1));
        add_row(mk_req(CMD_CANCEL, 20'd0, 1'b0, 16'd2), 1'b1,
                mk_rsp(KIND_CANCEL, 1'b0, 16'd0, 1'b1));
        add_row(mk_req(CMD_CANCEL, 20'd0, 1'b0, 16'd3), 1'b1,
                mk_rsp(KIND_CANCEL, 1'b1, 16'd3, 1'b1));
        add_row(mk_req(CMD_START, 20'd10, 1'b0, 16'd0), 1'b1,
                mk_rsp(KIND_START, 1'b1, 16'd6, 1'b1));
        add_row(mk_req(CMD_TICK, 20'd0, 1'b0, 16'd0), 1'b0, '0);
        add_row(mk_req(CMD_CANCEL, 20'd0, 1'b0, 16'd5), 1'b1,
                mk_rsp(KIND_CANCEL, 1'b1, 16'd5, 1'b1));
        add_row(mk_req(CMD_START, 20'd65535, 1'b1, 16'hFFFF), 1'b0, '0);
        add_row(mk_req(CMD_TICK, 20'hFFFFF, 1'b1, 16'hFFFF), 1'b0, '0);

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part; typed rows override the prediction
        foreach (plan[i])
        begin
            send(plan[i].stim);
            if (plan[i].typed)
                pending_results[pending_results.size() - 1] = plan[i].want;
        end
        drain_results();

        // Random part: mostly well-formed start/tick/cancel traffic
        base = items_in;
        while (items_in - base < RANDOM_ITEMS)
        begin
            calm = ($urandom_range(0, 9) == 0);
            roll = $urandom_range(0, 99);
            if (roll < 35)
            begin
                n = $urandom_range(1, 5);
                repeat (n)
                    send(mk_req(CMD_START, pick_ms(), 1'($urandom_range(0, 1)),
                                ID_W'($urandom_range(0, 16'hFFFF))));
            end
            else if (roll < 60)
            begin
                n = $urandom_range(1, 4);
                repeat (n)
                    send(mk_req(CMD_TICK, MS_W'($urandom_range(0, 20'hFFFFF)),
                                1'($urandom_range(0, 1)),
                                ID_W'($urandom_range(0, 16'hFFFF))));
            end
            else if (roll < 75)
            begin
                gather_live_ids();
                if (live_ids.size() > 0)
                    send(mk_req(CMD_CANCEL, pick_ms(), 1'($urandom_range(0, 1)),
                                live_ids[$urandom_range(0, live_ids.size() - 1)]));
            end
            else if (roll < 82)
                send(mk_req(CMD_CANCEL, pick_ms(), 1'($urandom_range(0, 1)),
                            ID_W'($urandom_range(0, 16'hFFFF))));
            else if (roll < 87)
            begin
                // fill the table, then one start too many
                while (count_active() < SLOTS)
                    send(mk_req(CMD_START, pick_ms(), 1'($urandom_range(0, 1)), 16'd0));
                send(mk_req(CMD_START, pick_ms(), 1'($urandom_range(0, 1)), 16'd0));
            end
            else if (roll < 91)
                cancel_all_live();
            else if (roll < 97)
                send(mk_req(CMD_W'($urandom_range(0, 3)), MS_W'($urandom_range(0, 20'hFFFFF)),
                            1'($urandom_range(0, 1)), ID_W'($urandom_range(0, 16'hFFFF))));
            else
                drain_results();
        end

        // Clear the table with the result side open, then one last tick
        calm = 1'b1;
        drain_results();
        cancel_all_live();
        send(mk_req(CMD_TICK, 20'd0, 1'b0, 16'd0));
        calm = 1'b0;

        // Wind down and look for stray results
        req_valid <= 1'b0;
        waited = 0;
        while (pending_results.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SLOTS + 8) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            missing = pending_results.size();
            $display("%0d expected results never arrived", missing);
        end

        $display("Covered %0d items: %0d starts placed, %0d refused on a full table,",
                 items_in, starts_placed, starts_refused);
        $display("%0d cancels hit, %0d missed, %0d expiries, %0d quiet ticks, %0d unused codes",
                 cancels_hit, cancels_missed, expiries, quiet_ticks, ignored_cmds);
        if (mismatches == 0 && missing == 0)
            $display("multi_slot_soft_timer_table test passed");
        else
            $display("multi_slot_soft_timer_table test failed");
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/msst_pkg.sv
hw/rtl/msst_cell.sv
hw/rtl/multi_slot_soft_timer_table.sv
hw/rtl/msst_checker.sv
tb/multi_slot_soft_timer_table_tb.sv
